// ----- sv/mh2_pkg.sv -----
// Shared types and constants for the streaming MurmurHash2 block.
// Used by mh2_front, mh2_back and murmur2_hash_stream; depends on nothing.
`default_nettype none

package mh2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned WORD_SHIFT  = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;
  localparam logic [31:0] SEED_RESET  = 32'd100;

  localparam int unsigned MID_DEPTH_DEFAULT = 4;
  localparam int unsigned OUT_DEPTH_DEFAULT = 2;

  // What the back end does with an item's word.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_FOLD = 2'd1,
    OP_TAIL = 2'd2
  } op_t;

  // One classified item on its way from the front end to the back end.
  // For a full word, data holds the mixed word; for a tail, the masked bytes.
  typedef struct packed {
    logic        start;
    logic [31:0] init;
    op_t         op;
    logic [31:0] data;
    logic        last;
  } mid_entry_t;

endpackage

`default_nettype wire

// ----- sv/murmur2_hash_stream.sv -----
// Streaming 32-bit MurmurHash2: front end, item queue, back end, result queue.
// Throughput is one item per cycle unless back-pressure from the result queue
// stalls it, set by the running-hash update loop of one multiply.
// Reset clears all queues and pipeline stages, the running hash to zero and
// the seed register to 100. Depends on mh2_pkg, mh2_front, mh2_fifo, mh2_back.
`default_nettype none

module murmur2_hash_stream
  import mh2_pkg::*;
#(
  parameter int unsigned MID_DEPTH = MID_DEPTH_DEFAULT,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [31:0] cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic        start_req,
  input  wire logic [31:0] msg_length,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        last,
  output logic             empty,
  input  wire logic        pop,
  output logic      [31:0] hash_value
);

  localparam int unsigned MID_W = $bits(mid_entry_t);

  logic [31:0]      seed;
  logic             mid_push;
  mid_entry_t       mid_in;
  logic             mid_full;
  logic             mid_pop;
  logic [MID_W-1:0] mid_out_bits;
  mid_entry_t       mid_out;
  logic             mid_empty;
  logic             res_push;
  logic [31:0]      res_data;
  logic             res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg_write) begin
      seed <= cfg_data;
    end
  end

  mh2_front u_front (
    .clk        (clk),
    .rst        (rst),
    .seed       (seed),
    .push       (push),
    .full       (full),
    .start_req  (start_req),
    .msg_length (msg_length),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .mid_push   (mid_push),
    .mid_entry  (mid_in),
    .mid_full   (mid_full)
  );

  mh2_fifo #(
    .DEPTH (MID_DEPTH),
    .WIDTH (MID_W)
  ) u_mid_q (
    .clk       (clk),
    .rst       (rst),
    .push      (mid_push),
    .push_data (mid_in),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_out_bits),
    .empty     (mid_empty)
  );

  assign mid_out = mid_entry_t'(mid_out_bits);

  mh2_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (!mid_empty),
    .entry       (mid_out),
    .entry_pop   (mid_pop),
    .res_push    (res_push),
    .res_data    (res_data),
    .res_full    (res_full)
  );

  mh2_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH (32)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (hash_value),
    .empty     (empty)
  );

  // Neither queue is ever pushed while it is full.
  assert property (@(posedge clk) disable iff (rst) mid_push |-> !mid_full)
    else $error("item queue pushed while full");

  assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result queue pushed while full");

  // The back end only takes an item that the queue holds.
  assert property (@(posedge clk) disable iff (rst) mid_pop |-> !mid_empty)
    else $error("item queue popped while empty");

  // Reset leaves no stale result behind.
  assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result visible right after reset");

endmodule

`default_nettype wire

// ----- sv/mh2_fifo.sv -----
// Small synchronous queue of registers with the head shown combinationally.
// Depends on nothing; DEPTH must be at least 2.
`default_nettype none

module mh2_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/mh2_front.sv -----
// Front end: accepts input items, classifies them and mixes full words
// in two multiply stages, masking the bytes of tails. Depends on mh2_pkg.
`default_nettype none

module mh2_front
  import mh2_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] seed,
  input  wire logic        push,
  output logic             full,
  input  wire logic        start_req,
  input  wire logic [31:0] msg_length,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        last,
  output logic             mid_push,
  output mid_entry_t       mid_entry,
  input  wire logic        mid_full
);

  function automatic logic [31:0] tail_mask(input logic [1:0] n);
    case (n)
      2'd1:    tail_mask = 32'h0000_00ff;
      2'd2:    tail_mask = 32'h0000_ffff;
      2'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'hffff_ffff;
    endcase
  endfunction

  logic        s1_valid;
  logic        s1_start;
  logic [31:0] s1_init;
  op_t         s1_op;
  logic [31:0] s1_p;
  logic        s1_last;
  logic        s1_ready;

  logic        s2_valid;
  mid_entry_t  s2_entry;
  logic        s2_ready;

  logic        take;
  op_t         op_in;
  logic [31:0] p_in;
  logic [31:0] k_shift;
  logic [31:0] k_mix;

  assign s2_ready  = !s2_valid || !mid_full;
  assign s1_ready  = !s1_valid || s2_ready;
  assign full      = !s1_ready;
  assign take      = push && s1_ready;
  assign mid_push  = s2_valid && !mid_full;
  assign mid_entry = s2_entry;

  // A non-last item, or a byte count of four or more, is a full word.
  always_comb begin
    if (!last || byte_count >= 3'd4) begin
      op_in = OP_FOLD;
    end else if (byte_count == 3'd0) begin
      op_in = OP_NONE;
    end else begin
      op_in = OP_TAIL;
    end
  end

  always_comb begin
    case (op_in)
      OP_FOLD: p_in = data_word * MIX_MUL;
      OP_TAIL: p_in = data_word & tail_mask(byte_count[1:0]);
      default: p_in = '0;
    endcase
  end

  assign k_shift = s1_p ^ (s1_p >> WORD_SHIFT);
  assign k_mix   = k_shift * MIX_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= take;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_start <= start_req;
      s1_init  <= seed ^ msg_length;
      s1_op    <= op_in;
      s1_p     <= p_in;
      s1_last  <= last;
    end
    if (s2_ready && s1_valid) begin
      s2_entry.start <= s1_start;
      s2_entry.init  <= s1_init;
      s2_entry.op    <= s1_op;
      s2_entry.data  <= (s1_op == OP_FOLD) ? k_mix : s1_p;
      s2_entry.last  <= s1_last;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mh2_back.sv -----
// Back end: folds classified items into the running hash and runs the
// final avalanche for last items. Depends on mh2_pkg.
`default_nettype none

module mh2_back
  import mh2_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        entry_valid,
  input  mid_entry_t       entry,
  output logic             entry_pop,
  output logic             res_push,
  output logic      [31:0] res_data,
  input  wire logic        res_full
);

  logic [31:0] running_hash;
  logic [31:0] h_base;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic [31:0] h_next;

  logic        av1_valid;
  logic [31:0] av1_h;
  logic        av1_ready;
  logic        av2_valid;
  logic [31:0] av2_m;
  logic        av2_ready;
  logic [31:0] av_mix;

  assign av2_ready = !av2_valid || !res_full;
  assign av1_ready = !av1_valid || av2_ready;
  assign entry_pop = entry_valid && av1_ready;

  assign h_base = entry.start ? entry.init : running_hash;
  assign mul_a  = (entry.op == OP_TAIL) ? (h_base ^ entry.data) : h_base;
  assign prod   = mul_a * MIX_MUL;

  always_comb begin
    case (entry.op)
      OP_FOLD: h_next = prod ^ entry.data;
      OP_TAIL: h_next = prod;
      default: h_next = h_base;
    endcase
  end

  assign av_mix   = (av1_h ^ (av1_h >> FIN_SHIFT_A)) * MIX_MUL;
  assign res_data = av2_m ^ (av2_m >> FIN_SHIFT_B);
  assign res_push = av2_valid && !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      av1_valid    <= 1'b0;
      av2_valid    <= 1'b0;
    end else begin
      if (entry_pop) begin
        running_hash <= h_next;
      end
      if (av1_ready) begin
        av1_valid <= entry_pop && entry.last;
      end
      if (av2_ready) begin
        av2_valid <= av1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (entry_pop && entry.last) begin
      av1_h <= h_next;
    end
    if (av2_ready && av1_valid) begin
      av2_m <= av_mix;
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for murmur2_hash_stream: a scoreboard class predicts each
// message hash and checks it in order. Depends on mh2_pkg and murmur2_hash_stream.
`timescale 1ns / 1ps

module tb_top
  import mh2_pkg::*;
;

  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned TOTAL_ITEMS   = 1450;

  class hash_scoreboard;
    logic [31:0] seed;
    logic [31:0] running_hash;
    logic [31:0] expected_hashes[$];
    int unsigned mismatches;

    function new();
      seed = SEED_RESET;
      running_hash = '0;
      mismatches = 0;
    endfunction

    function void load_seed(logic [31:0] value);
      seed = value;
    endfunction

    function logic [31:0] fold_word(logic [31:0] h, logic [31:0] w);
      logic [31:0] k;
      k = w * MIX_MUL;
      k = k ^ (k >> WORD_SHIFT);
      k = k * MIX_MUL;
      return (h * MIX_MUL) ^ k;
    endfunction

    function logic [31:0] finalize(logic [31:0] h);
      logic [31:0] f;
      f = h ^ (h >> FIN_SHIFT_A);
      f = f * MIX_MUL;
      return f ^ (f >> FIN_SHIFT_B);
    endfunction

    // Advances the running hash by one accepted item.
    function void note_item(logic is_start, logic [31:0] len, logic [31:0] word,
                            logic [2:0] cnt, logic is_last);
      logic [31:0] h;
      logic [31:0] mask;
      h = is_start ? (seed ^ len) : running_hash;
      if (!is_last || cnt >= 3'd4) begin
        h = fold_word(h, word);
      end else if (cnt != 3'd0) begin
        mask = (32'h1 << (8 * int'(cnt))) - 32'h1;
        h = (h ^ (word & mask)) * MIX_MUL;
      end
      running_hash = h;
      if (is_last) expected_hashes.push_back(finalize(h));
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_hash(logic [31:0] got);
      logic [31:0] want;
      if (expected_hashes.size() == 0) begin
        flag($sformatf("unexpected hash %08h with nothing pending", got));
      end else begin
        want = expected_hashes.pop_front();
        if (got !== want) flag($sformatf("hash_value: expected %08h, got %08h", want, got));
      end
    endfunction

    function int pending();
      return expected_hashes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [31:0] cfg_data;
  logic        push;
  logic        full;
  logic        start_req;
  logic [31:0] msg_length;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;
  logic        empty;
  logic        pop;
  logic [31:0] hash_value;

  hash_scoreboard sb = new();
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on = 1'b1;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  murmur2_hash_stream dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .start_req  (start_req),
    .msg_length (msg_length),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .empty      (empty),
    .pop        (pop),
    .hash_value (hash_value)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("** murmur2_hash_stream: FAILED **");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, none when quiet.
  initial begin
    int unsigned stall;
    int unsigned hold;
    logic        next_pop;
    stall = 0;
    hold = 0;
    pop <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_hash(hash_value);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        next_pop = 1'b0;
      end else if (stall > 0) begin
        stall--;
        next_pop = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 16) - 1;
        next_pop = 1'b0;
      end else begin
        next_pop = 1'b1;
      end
      pop <= next_pop;
    end
  end

  task automatic send_item(logic is_start, logic [31:0] len, logic [31:0] word,
                           logic [2:0] cnt, logic is_last);
    push       <= 1'b1;
    start_req  <= is_start;
    msg_length <= len;
    data_word  <= word;
    byte_count <= cnt;
    last       <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(is_start, len, word, cnt, is_last);
    items_sent++;
    if (gaps_on && !quiet && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_noise();
    send_item(1'($urandom_range(0, 1)), $urandom, $urandom, 3'($urandom_range(0, 7)),
              1'($urandom_range(0, 1)));
  endtask

  // One well-formed message of random content; the length field is sometimes wrong.
  task automatic send_random_message();
    int unsigned nbytes;
    int unsigned nfull;
    int unsigned tail;
    int unsigned total;
    logic [31:0] len_field;
    logic [2:0]  cnt;
    bit          zero_end;
    bit          is_last;
    nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 256) : $urandom_range(0, 40);
    len_field = ($urandom_range(0, 15) == 0) ? $urandom : nbytes;
    nfull = nbytes / 4;
    tail = nbytes % 4;
    zero_end = (tail == 0) && (nfull == 0 || $urandom_range(0, 1) == 1);
    total = (tail != 0 || zero_end) ? nfull + 1 : nfull;
    for (int unsigned i = 0; i < total; i++) begin
      is_last = (i == total - 1);
      if (!is_last) cnt = 3'($urandom_range(0, 7));
      else if (tail != 0) cnt = 3'(tail);
      else if (zero_end) cnt = 3'd0;
      else cnt = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(4, 7)) : 3'd4;
      send_item(i == 0, (i == 0) ? len_field : $urandom, $urandom, cnt, is_last);
    end
  endtask

  task automatic run_random(int unsigned target);
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 85) send_random_message();
      else send_noise();
    end
  endtask

  // Waits for every pending hash, lets the pipeline settle, then writes the seed.
  task automatic drain_and_seed(logic [31:0] value);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.load_seed(value);
  endtask

  initial begin
    int unsigned target;
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_data   <= '0;
    push       <= 1'b0;
    start_req  <= 1'b0;
    msg_length <= '0;
    data_word  <= '0;
    byte_count <= '0;
    last       <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items run with the reset seed. The first two have no start and
    // continue from the cleared running hash.
    send_item(1'b0, 32'h0, 32'hDEADBEEF, 3'd0, 1'b0);
    send_item(1'b0, 32'h0, 32'h00C0FFEE, 3'd2, 1'b1);
    send_item(1'b1, 32'd0, 32'hFFFFFFFF, 3'd0, 1'b1);
    send_item(1'b1, 32'd4, 32'hFFFFFFFF, 3'd4, 1'b1);
    send_item(1'b1, 32'd1, 32'hA5A5A5A5, 3'd1, 1'b1);
    send_item(1'b1, 32'd2, 32'h5A5A5A5A, 3'd2, 1'b1);
    send_item(1'b1, 32'd3, 32'hFFFFFFFF, 3'd3, 1'b1);
    send_item(1'b1, 32'd8, 32'h00000000, 3'd1, 1'b0);
    send_item(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 3'd4, 1'b1);
    send_item(1'b1, 32'd5, 32'h12345678, 3'd7, 1'b0);
    send_item(1'b0, 32'd0, 32'h87654321, 3'd5, 1'b1);
    send_item(1'b1, 32'd4, 32'h0BADF00D, 3'd6, 1'b1);
    send_item(1'b1, 32'hFFFFFFFF, 32'h80000001, 3'd7, 1'b0);
    send_item(1'b0, 32'd0, 32'h7FFFFFFE, 3'd0, 1'b1);
    // Hashing goes on after a last item when no new start comes.
    send_item(1'b0, 32'hFFFFFFFF, 32'h00000001, 3'd3, 1'b0);
    send_item(1'b0, 32'd0, 32'hFFFFFF00, 3'd1, 1'b1);
    send_item(1'b1, 32'hFFFFFFFF, 32'h00000000, 3'd0, 1'b1);
    send_item(1'b1, 32'd0, 32'hFFFFFFFF, 3'd3, 1'b1);

    drain_and_seed(32'h0000_0000);
    run_random(200);

    // The result side holds off while items keep coming, so the block fills up.
    gaps_on = 1'b0;
    hold_req = 1'b1;
    target = items_sent + 40;
    while (items_sent < target) send_random_message();
    gaps_on = 1'b1;
    run_random(500);

    drain_and_seed(32'hFFFF_FFFF);
    run_random(850);
    drain_and_seed($urandom);
    run_random(1150);

    drain_and_seed($urandom);
    quiet = 1'b1;
    run_random(TOTAL_ITEMS);

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** murmur2_hash_stream: PASSED **");
    end else begin
      $display("** murmur2_hash_stream: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/mh2_pkg.sv
sv/mh2_fifo.sv
sv/mh2_front.sv
sv/mh2_back.sv
sv/murmur2_hash_stream.sv
bench/tb_top.sv
